// ===== hdl/uig_pkg.sv =====
// ----------------------------------------------------------------------------
// UDP/IPv4 frame generator package
// Shared types, register indexes and frame constants.
// ----------------------------------------------------------------------------
package uig_pkg;

  localparam int LEN_W = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam int MIN_FRAME_BYTES = 60;
  localparam int MAX_FRAME_BYTES = 1514;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_DEST_MAC     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_MAC   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_IP    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DEST_IP      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_PORT  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DEST_PORT    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_HOP_LIMIT    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LENGTH = 3'd7;

  localparam logic [7:0]       HOP_LIMIT_RST    = 8'd64;
  localparam logic [LEN_W-1:0] FRAME_LENGTH_RST = 11'd60;

  // Fixed header and payload bytes
  localparam logic [7:0]  ETHERTYPE_HI = 8'h08;
  localparam logic [7:0]  IP_VER_IHL   = 8'h45;
  localparam logic [7:0]  IP_PROTO_UDP = 8'd17;
  localparam logic [7:0]  PAYLOAD_BYTE = 8'h55;
  localparam logic [LEN_W-1:0] PAYLOAD_START = 11'd42;
  localparam logic [LEN_W-1:0] ETH_HDR_BYTES = 11'd14;
  localparam logic [LEN_W-1:0] UDP_START     = 11'd34;

  typedef struct packed {
    logic [47:0]      dest_mac;
    logic [47:0]      source_mac;
    logic [31:0]      source_ip;
    logic [31:0]      dest_ip;
    logic [15:0]      source_port;
    logic [15:0]      dest_port;
    logic [7:0]       hop_limit;
    logic [LEN_W-1:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic             last_byte;
    logic [LEN_W-1:0] byte_offset;
    logic [7:0]       data_byte;
  } res_t;

endpackage

// ===== hdl/udp_ipv4_frame_generator_unit.sv =====
// ----------------------------------------------------------------------------
// UDP/IPv4 frame generator
// An input beat is registered in the output register, or in the skid stage
// on a stall. Throughput: one frame byte per cycle unless the output stalls;
// the byte engine is single pass between the position register and the
// output register, and a skid stage absorbs one beat of output stall.
// Reset: position and checksum clear, config returns to defaults (TTL 64,
// frame length 60); no clearing pass.
// ----------------------------------------------------------------------------
module udp_ipv4_frame_generator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // restart in bit 0
  input  logic [7:0]                     s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // data_byte [7:0], byte_offset [18:8], zero fill [23:19]
  output logic [23:0]                    m_axis_tdata,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [uig_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [uig_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import uig_pkg::*;

  cfg_t cfg;
  res_t gen_res;
  res_t out_res;
  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  uig_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  uig_byte_gen u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (in_acc),
    .restart_i (s_axis_tdata[0]),
    .res_o     (gen_res)
  );

  uig_out_buf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_res_i    (gen_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.byte_offset, out_res.data_byte};
  assign m_axis_tlast = out_res.last_byte;

endmodule

// ===== hdl/uig_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// UDP/IPv4 frame generator configuration registers
// Write-only register file holding addresses, ports, TTL and frame length.
// ----------------------------------------------------------------------------
module uig_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uig_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [uig_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output uig_pkg::cfg_t                  cfg_o
);
  import uig_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_mac     <= '0;
      cfg_q.source_mac   <= '0;
      cfg_q.source_ip    <= '0;
      cfg_q.dest_ip      <= '0;
      cfg_q.source_port  <= '0;
      cfg_q.dest_port    <= '0;
      cfg_q.hop_limit    <= HOP_LIMIT_RST;
      cfg_q.frame_length <= FRAME_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DEST_MAC:     cfg_q.dest_mac     <= cfg_wdata_i;
        REG_SOURCE_MAC:   cfg_q.source_mac   <= cfg_wdata_i;
        REG_SOURCE_IP:    cfg_q.source_ip    <= cfg_wdata_i[31:0];
        REG_DEST_IP:      cfg_q.dest_ip      <= cfg_wdata_i[31:0];
        REG_SOURCE_PORT:  cfg_q.source_port  <= cfg_wdata_i[15:0];
        REG_DEST_PORT:    cfg_q.dest_port    <= cfg_wdata_i[15:0];
        REG_HOP_LIMIT:    cfg_q.hop_limit    <= cfg_wdata_i[7:0];
        REG_FRAME_LENGTH: cfg_q.frame_length <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/uig_byte_gen.sv =====
// ----------------------------------------------------------------------------
// UDP/IPv4 frame generator byte engine
// Tracks the frame position, latches the IPv4 header checksum at frame
// start and selects the frame byte for the current offset.
// ----------------------------------------------------------------------------
module uig_byte_gen (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  uig_pkg::cfg_t cfg_i,
  input  logic          advance_i,
  input  logic          restart_i,
  output uig_pkg::res_t res_o
);
  import uig_pkg::*;

  logic [LEN_W-1:0] pos_q, pos_d;
  logic [15:0]      csum_q, csum_d;

  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] ip_len;
  logic [LEN_W-1:0] udp_len;
  logic             frame_start;
  logic [LEN_W-1:0] off;
  logic             last;
  logic [2:0]       dmac_idx;
  logic [3:0]       smac_sel;
  logic [2:0]       smac_idx;
  logic [7:0]       byte_val;

  // RFC 791 ones-complement sum with end-around carry, complemented
  function automatic logic [15:0] ip_csum(input logic [LEN_W-1:0] tot_len,
                                          input cfg_t c);
    logic [18:0] s;
    logic [16:0] f1;
    logic [15:0] f2;
    s  = 19'({IP_VER_IHL, 8'h00}) + 19'(tot_len) + 19'({c.hop_limit, IP_PROTO_UDP})
       + 19'(c.source_ip[31:16]) + 19'(c.source_ip[15:0])
       + 19'(c.dest_ip[31:16]) + 19'(c.dest_ip[15:0]);
    f1 = 17'(s[15:0]) + 17'(s[18:16]);
    f2 = f1[15:0] + 16'(f1[16]);
    return ~f2;
  endfunction

  always_comb begin
    if (cfg_i.frame_length < LEN_W'(MIN_FRAME_BYTES)) begin
      eff_len = LEN_W'(MIN_FRAME_BYTES);
    end else if (cfg_i.frame_length > LEN_W'(MAX_FRAME_BYTES)) begin
      eff_len = LEN_W'(MAX_FRAME_BYTES);
    end else begin
      eff_len = cfg_i.frame_length;
    end
  end

  assign ip_len  = eff_len - ETH_HDR_BYTES;
  assign udp_len = eff_len - UDP_START;

  // A new frame begins on restart, after the last byte, or when the length
  // shrank to or below the current position.
  assign frame_start = restart_i || (pos_q == '0) || (pos_q >= eff_len);
  assign off         = frame_start ? '0 : pos_q;
  assign csum_d      = frame_start ? ip_csum(ip_len, cfg_i) : csum_q;
  assign last        = (off == eff_len - LEN_W'(1));
  assign pos_d       = last ? '0 : off + LEN_W'(1);

  assign dmac_idx = 3'd5 - off[2:0];
  assign smac_sel = 4'd11 - off[3:0];
  assign smac_idx = smac_sel[2:0];

  always_comb begin
    if (off < LEN_W'(6)) begin
      byte_val = cfg_i.dest_mac[{dmac_idx, 3'b000} +: 8];
    end else if (off < LEN_W'(12)) begin
      byte_val = cfg_i.source_mac[{smac_idx, 3'b000} +: 8];
    end else begin
      case (off)
        11'd12:  byte_val = ETHERTYPE_HI;
        11'd14:  byte_val = IP_VER_IHL;
        11'd16:  byte_val = {5'b0, ip_len[10:8]};
        11'd17:  byte_val = ip_len[7:0];
        11'd22:  byte_val = cfg_i.hop_limit;
        11'd23:  byte_val = IP_PROTO_UDP;
        11'd24:  byte_val = csum_d[15:8];
        11'd25:  byte_val = csum_d[7:0];
        11'd26:  byte_val = cfg_i.source_ip[31:24];
        11'd27:  byte_val = cfg_i.source_ip[23:16];
        11'd28:  byte_val = cfg_i.source_ip[15:8];
        11'd29:  byte_val = cfg_i.source_ip[7:0];
        11'd30:  byte_val = cfg_i.dest_ip[31:24];
        11'd31:  byte_val = cfg_i.dest_ip[23:16];
        11'd32:  byte_val = cfg_i.dest_ip[15:8];
        11'd33:  byte_val = cfg_i.dest_ip[7:0];
        11'd34:  byte_val = cfg_i.source_port[15:8];
        11'd35:  byte_val = cfg_i.source_port[7:0];
        11'd36:  byte_val = cfg_i.dest_port[15:8];
        11'd37:  byte_val = cfg_i.dest_port[7:0];
        11'd38:  byte_val = {5'b0, udp_len[10:8]};
        11'd39:  byte_val = udp_len[7:0];
        default: byte_val = (off >= PAYLOAD_START) ? PAYLOAD_BYTE : 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      csum_q <= '0;
    end else if (advance_i) begin
      pos_q  <= pos_d;
      csum_q <= csum_d;
    end
  end

  assign res_o.data_byte   = byte_val;
  assign res_o.byte_offset = off;
  assign res_o.last_byte   = last;

endmodule

// ===== hdl/uig_out_buf.sv =====
// ----------------------------------------------------------------------------
// UDP/IPv4 frame generator output buffer
// Output register plus skid stage that takes one more input beat on a stall.
// ----------------------------------------------------------------------------
module uig_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  uig_pkg::res_t in_res_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output uig_pkg::res_t out_res_o
);
  import uig_pkg::*;

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_res_q;
  res_t skid_res_q;
  logic out_free;
  logic in_acc;

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // drain the skid beat first; a new beat cannot arrive while it is full
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_res_q <= skid_valid_q ? skid_res_q : in_res_i;
    end else if (in_acc) begin
      skid_res_q <= in_res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ===== hdl/uig_checker.sv =====
// ----------------------------------------------------------------------------
// UDP/IPv4 frame generator port checker
// Checks stall behavior, fixed and payload bytes and tlast offsets on the ports.
// ----------------------------------------------------------------------------
module uig_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready
);
  import uig_pkg::*;

  logic             out_acc;
  logic [LEN_W-1:0] out_off;
  logic [7:0]       out_byte;

  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign out_off  = m_axis_tdata[18:8];
  assign out_byte = m_axis_tdata[7:0];

  // hold a stalled beat
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_fixed_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (out_off == 11'd12 || out_off == 11'd14 || out_off == 11'd23) |->
      ((out_off == 11'd12) && (out_byte == ETHERTYPE_HI)) ||
      ((out_off == 11'd14) && (out_byte == IP_VER_IHL)) ||
      ((out_off == 11'd23) && (out_byte == IP_PROTO_UDP)))
    else $error("fixed header byte wrong");

  a_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (out_off >= PAYLOAD_START) |-> out_byte == PAYLOAD_BYTE)
    else $error("payload byte wrong");

  a_last_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tlast |->
      (out_off >= LEN_W'(MIN_FRAME_BYTES - 1)) && (out_off <= LEN_W'(MAX_FRAME_BYTES - 1)))
    else $error("last byte at impossible offset");

endmodule

bind udp_ipv4_frame_generator_unit uig_checker u_uig_checker (.*);

// ===== tb/sv/tb_udp_ipv4_frame_generator_unit.sv =====
// ----------------------------------------------------------------------------
// UDP/IPv4 frame generator testbench
// Drives restart/advance beats into the generator and checks every output
// byte, its offset and the last-byte mark against a frame predictor. The
// predictor tracks the configuration and the frame position itself. The
// configuration changes between phases, only while the generator is drained.
// Both stream sides idle in random bursts. A long output stall fills the
// generator, and a full frame is sent at the largest length.
// ----------------------------------------------------------------------------
module tb_udp_ipv4_frame_generator_unit;
  import uig_pkg::*;

  localparam int ITEM_TARGET = 1600;
  localparam int CALM_AFTER  = 1400;
  localparam int WATCHDOG    = 4000;
  localparam int LONG_HOLD   = 200;

  class frame_scoreboard;
    cfg_t             regs;
    logic [LEN_W-1:0] next_pos;
    logic [15:0]      frame_cksum;
    res_t             expected_bytes[$];
    int               errors;

    function new();
      regs = '0;
      regs.hop_limit = HOP_LIMIT_RST;
      regs.frame_length = FRAME_LENGTH_RST;
      next_pos = '0;
      frame_cksum = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DEST_MAC:     regs.dest_mac = val[47:0];
        REG_SOURCE_MAC:   regs.source_mac = val[47:0];
        REG_SOURCE_IP:    regs.source_ip = val[31:0];
        REG_DEST_IP:      regs.dest_ip = val[31:0];
        REG_SOURCE_PORT:  regs.source_port = val[15:0];
        REG_DEST_PORT:    regs.dest_port = val[15:0];
        REG_HOP_LIMIT:    regs.hop_limit = val[7:0];
        REG_FRAME_LENGTH: regs.frame_length = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp the programmed length into the legal frame range
    function int unsigned frame_len();
      int unsigned l;
      l = 32'(regs.frame_length);
      if (l < MIN_FRAME_BYTES) l = MIN_FRAME_BYTES;
      if (l > MAX_FRAME_BYTES) l = MAX_FRAME_BYTES;
      return l;
    endfunction

    // Ones-complement header sum with end-around carry
    function logic [15:0] ip_header_cksum(int unsigned len);
      int unsigned s;
      s = 32'({IP_VER_IHL, 8'h00});
      s += (len - 32'(ETH_HDR_BYTES)) & 32'hFFFF;
      s += 32'({regs.hop_limit, IP_PROTO_UDP});
      s += 32'(regs.source_ip[31:16]) + 32'(regs.source_ip[15:0]);
      s += 32'(regs.dest_ip[31:16]) + 32'(regs.dest_ip[15:0]);
      while (s > 32'hFFFF) s = (s & 32'hFFFF) + (s >> 16);
      return ~s[15:0];
    endfunction

    function logic [7:0] byte_at(int unsigned off, int unsigned len);
      logic [15:0] ip_len;
      logic [15:0] udp_len;
      ip_len = 16'(len - 32'(ETH_HDR_BYTES));
      udp_len = 16'(len - 32'(UDP_START));
      if (off < 6) return regs.dest_mac[8*(5-off) +: 8];
      if (off < 12) return regs.source_mac[8*(11-off) +: 8];
      case (off)
        12: return ETHERTYPE_HI;
        14: return IP_VER_IHL;
        16: return ip_len[15:8];
        17: return ip_len[7:0];
        22: return regs.hop_limit;
        23: return IP_PROTO_UDP;
        24: return frame_cksum[15:8];
        25: return frame_cksum[7:0];
        26: return regs.source_ip[31:24];
        27: return regs.source_ip[23:16];
        28: return regs.source_ip[15:8];
        29: return regs.source_ip[7:0];
        30: return regs.dest_ip[31:24];
        31: return regs.dest_ip[23:16];
        32: return regs.dest_ip[15:8];
        33: return regs.dest_ip[7:0];
        34: return regs.source_port[15:8];
        35: return regs.source_port[7:0];
        36: return regs.dest_port[15:8];
        37: return regs.dest_port[7:0];
        38: return udp_len[15:8];
        39: return udp_len[7:0];
        default: return (off >= PAYLOAD_START) ? PAYLOAD_BYTE : 8'h00;
      endcase
    endfunction

    function void note_input(logic restart);
      int unsigned len;
      int unsigned off;
      res_t r;
      len = frame_len();
      off = 32'(next_pos);
      // Start a new frame on request, after the last byte, or past the end
      if (restart || off == 0 || off >= len) begin
        off = 0;
        frame_cksum = ip_header_cksum(len);
      end
      r.last_byte = (off == len - 1);
      r.byte_offset = LEN_W'(off);
      r.data_byte = byte_at(off, len);
      expected_bytes.push_back(r);
      next_pos = r.last_byte ? '0 : LEN_W'(off + 1);
    endfunction

    function void check_result(logic [7:0] data, logic [LEN_W-1:0] off, logic last);
      res_t e;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output beat: data_byte %0h byte_offset %0d", data, off);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (data !== e.data_byte) begin
        $error("data_byte: expected %0h, got %0h", e.data_byte, data);
        errors++;
      end
      if (off !== e.byte_offset) begin
        $error("byte_offset: expected %0d, got %0d", e.byte_offset, off);
        errors++;
      end
      if (last !== e.last_byte) begin
        $error("last_byte: expected %0b, got %0b", e.last_byte, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [7:0]            s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  frame_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int idle_cycles = 0;

  udp_ipv4_frame_generator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Output side: random stalls, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready)
      sb.check_result(m_axis_tdata[7:0], m_axis_tdata[18:8], m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic restart, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(restart);
    items_sent++;
  endtask

  // Stop offering and wait until every byte has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_value(int width);
    logic [CFG_DATA_W-1:0] ones;
    int r;
    ones = (48'h1 << width) - 48'h1;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return ones;
    return CFG_DATA_W'({$urandom, $urandom}) & ones;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CFG_DATA_W'($urandom_range(0, MIN_FRAME_BYTES - 1));
    if (r == 1) return CFG_DATA_W'($urandom_range(MAX_FRAME_BYTES + 1, 2047));
    if (r == 2) return CFG_DATA_W'($urandom_range(101, 400));
    return CFG_DATA_W'($urandom_range(MIN_FRAME_BYTES, 100));
  endfunction

  task automatic send_run(input int count, input int restart_odds, input bit quiet);
    int gap;
    for (int i = 0; i < count; i++) begin
      gap = 0;
      if (!quiet && !calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
      send_beat(restart_odds > 0 && $urandom_range(1, restart_odds) == 1, gap);
      if (items_sent >= CALM_AFTER) calm = 1'b1;
    end
  endtask

  initial begin
    int phase;
    int count;
    bit quiet;
    phase = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: start from position zero, then a forced restart
    send_beat(1'b0, 0);
    send_beat(1'b0, 0);
    send_beat(1'b0, 2);
    send_beat(1'b1, 0);
    send_beat(1'b0, 0);
    drain();

    // All-ones registers, length above range clamps to the maximum
    write_cfg(REG_DEST_MAC, 48'hFFFF_FFFF_FFFF);
    write_cfg(REG_SOURCE_MAC, 48'hFFFF_FFFF_FFFF);
    write_cfg(REG_SOURCE_IP, 48'hFFFF_FFFF);
    write_cfg(REG_DEST_IP, 48'hFFFF_FFFF);
    write_cfg(REG_SOURCE_PORT, 48'hFFFF);
    write_cfg(REG_DEST_PORT, 48'hFFFF);
    write_cfg(REG_HOP_LIMIT, 48'hFF);
    write_cfg(REG_FRAME_LENGTH, 48'h7FF);
    cfg_we <= 1'b0;
    send_run(64, 0, 1'b1);
    drain();

    // All-zero registers, length below range; position is now past the end
    write_cfg(REG_DEST_MAC, '0);
    write_cfg(REG_SOURCE_MAC, '0);
    write_cfg(REG_SOURCE_IP, '0);
    write_cfg(REG_DEST_IP, '0);
    write_cfg(REG_SOURCE_PORT, '0);
    write_cfg(REG_DEST_PORT, '0);
    write_cfg(REG_HOP_LIMIT, '0);
    write_cfg(REG_FRAME_LENGTH, '0);
    cfg_we <= 1'b0;
    send_run(62, 0, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      drain();
      for (int idx = 0; idx < 7; idx++) begin
        if (phase == 0 || $urandom_range(0, 1) == 1) begin
          case (idx)
            0: write_cfg(REG_DEST_MAC, pick_value(48));
            1: write_cfg(REG_SOURCE_MAC, pick_value(48));
            2: write_cfg(REG_SOURCE_IP, pick_value(32));
            3: write_cfg(REG_DEST_IP, pick_value(32));
            4: write_cfg(REG_SOURCE_PORT, pick_value(16));
            5: write_cfg(REG_DEST_PORT, pick_value(16));
            default: write_cfg(REG_HOP_LIMIT, pick_value(8));
          endcase
        end
      end
      if (phase == 2) begin
        // One full frame at the largest length and the start of the next, no restarts
        write_cfg(REG_FRAME_LENGTH, CFG_DATA_W'(MAX_FRAME_BYTES));
        cfg_we <= 1'b0;
        send_run(MAX_FRAME_BYTES + 5, 0, 1'b0);
      end else begin
        write_cfg(REG_FRAME_LENGTH, pick_length());
        cfg_we <= 1'b0;
        count = $urandom_range(20, 80);
        quiet = ($urandom_range(0, 2) == 0);
        if (phase == 1) begin
          // Hold the output off while input keeps coming so the block backs up
          hold_req = 1'b1;
          wait (!hold_req);
          send_run(count, 40, 1'b1);
        end else if (phase == 3) begin
          send_run(count / 2, 40, quiet);
          s_tvalid <= 1'b0;
          do @(posedge clk_i); while (sb.outstanding() != 0);
          send_run(count - count / 2, 40, quiet);
        end else begin
          send_run(count, 40, quiet);
        end
      end
      phase++;
    end

    drain();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
